@@ hdl/ccs_pkg.sv @@
// shared types and constants for the cellular cave smoothing block
package ccs_pkg;

    localparam int CMD_W      = 2;
    localparam int ROW_W      = 6;
    localparam int COL_W      = 7;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int THR_W      = 4;
    localparam int ROWS_CFG_W = 7;
    localparam int COLS_CFG_W = 8;
    localparam int CNT_W      = 4;

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RUN   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BIRTH_MIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEATH_MAX    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BORDER_ALIVE = 3'd4;

    localparam logic [THR_W-1:0]      BIRTH_MIN_RST = 4'd6;
    localparam logic [THR_W-1:0]      DEATH_MAX_RST = 4'd3;
    localparam logic [ROWS_CFG_W-1:0] ROWS_RST      = 7'd60;
    localparam logic [COLS_CFG_W-1:0] COLS_RST      = 8'd100;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_ACC_READ,
        OP_RESPOND,
        OP_G_INIT,
        OP_G_LOAD_CUR,
        OP_G_LOAD_NEXT,
        OP_G_CELL,
        OP_G_ROW_END
    } ccs_op_t;

    typedef struct packed {
        ccs_op_t op;
        logic    latch_in;
    } ccs_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic grid_empty;
        logic col_last;
        logic row_last;
        logic out_free;
    } ccs_stat_t;

endpackage

@@ hdl/ccs_if.sv @@
// handshake channel interfaces: input items, result items, configuration writes
interface ccs_in_if;
    logic                      valid;
    logic                      ready;
    logic [ccs_pkg::CMD_W-1:0] cmd;
    logic [ccs_pkg::ROW_W-1:0] row;
    logic [ccs_pkg::COL_W-1:0] col;
    logic                      cell_in;

    modport source (output valid, cmd, row, col, cell_in, input ready);
    modport sink (input valid, cmd, row, col, cell_in, output ready);
endinterface

interface ccs_out_if;
    logic valid;
    logic ready;
    logic cell_out;
    logic status;

    modport source (output valid, cell_out, status, input ready);
    modport sink (input valid, cell_out, status, output ready);
endinterface

interface ccs_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ccs_pkg::CFG_IDX_W-1:0]  index;
    logic [ccs_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/cellular_cave_smoothing_top.sv @@
// top level of the cellular cave smoothing block
// The grid is held as MAX_ROWS words of MAX_COLS bits in one memory with a
// write port and a registered read port. After reset a clearing pass writes
// one row per cycle through all MAX_ROWS rows with in_ch.ready low; config
// beats are taken throughout. A write or read beat passes an access state and
// a response state and yields one result beat; a result still waiting on
// out_ch holds off the response and so the next input. A run beat yields no
// result: the scan updates one cell per cycle from a three-row window, with
// write-back and load states per row to write back and fetch the row below.
module cellular_cave_smoothing_top #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 128
)
(
    input  logic   clk,
    input  logic   rst_n,
    ccs_in_if.sink     in_ch,
    ccs_out_if.source  out_ch,
    ccs_cfg_if.sink    cfg_ch
);

    ccs_pkg::ccs_cmd_t  ctl;
    ccs_pkg::ccs_stat_t stat;

    assign cfg_ch.ready = 1'b1;

    ccs_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .in_cmd   (in_ch.cmd),
        .stat     (stat),
        .ctl      (ctl)
    );

    ccs_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .stat      (stat),
        .in_cmd    (in_ch.cmd),
        .in_row    (in_ch.row),
        .in_col    (in_ch.col),
        .in_cell   (in_ch.cell_in),
        .cfg_valid (cfg_ch.valid),
        .cfg_index (cfg_ch.index),
        .cfg_data  (cfg_ch.data),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cell_out  (out_ch.cell_out),
        .status    (out_ch.status)
    );

endmodule

@@ hdl/ccs_ctrl.sv @@
// controller state machine sequencing clear, cell access and generation scan
module ccs_ctrl
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [ccs_pkg::CMD_W-1:0] in_cmd,
    input  ccs_pkg::ccs_stat_t        stat,
    output ccs_pkg::ccs_cmd_t         ctl
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ACC,
        S_RESP,
        S_GINIT,
        S_GCUR,
        S_GNEXT,
        S_GCELL,
        S_GWB
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next   = state_reg;
        ctl.op       = ccs_pkg::OP_NONE;
        ctl.latch_in = accept;
        case (state_reg)
            S_CLEAR:
            begin
                ctl.op = ccs_pkg::OP_CLEAR;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_cmd)
                        ccs_pkg::CMD_WRITE: state_next = S_ACC;
                        ccs_pkg::CMD_READ:  state_next = S_ACC;
                        ccs_pkg::CMD_RUN:   state_next = S_GINIT;
                        default:            state_next = S_IDLE;
                    endcase
                end
            end
            S_ACC:
            begin
                ctl.op     = ccs_pkg::OP_ACC_READ;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (stat.out_free)
                begin
                    ctl.op     = ccs_pkg::OP_RESPOND;
                    state_next = S_IDLE;
                end
            end
            S_GINIT:
            begin
                if (stat.grid_empty)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    ctl.op     = ccs_pkg::OP_G_INIT;
                    state_next = S_GCUR;
                end
            end
            S_GCUR:
            begin
                ctl.op     = ccs_pkg::OP_G_LOAD_CUR;
                state_next = S_GNEXT;
            end
            S_GNEXT:
            begin
                ctl.op     = ccs_pkg::OP_G_LOAD_NEXT;
                state_next = S_GCELL;
            end
            S_GCELL:
            begin
                ctl.op = ccs_pkg::OP_G_CELL;
                if (stat.col_last)
                begin
                    state_next = S_GWB;
                end
            end
            S_GWB:
            begin
                ctl.op     = ccs_pkg::OP_G_ROW_END;
                state_next = stat.row_last ? S_IDLE : S_GNEXT;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ hdl/ccs_datapath.sv @@
// grid memory, three-row scan window, neighbor count, config and result registers
module ccs_datapath #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 128
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  ccs_pkg::ccs_cmd_t              ctl,
    output ccs_pkg::ccs_stat_t             stat,
    input  logic [ccs_pkg::CMD_W-1:0]      in_cmd,
    input  logic [ccs_pkg::ROW_W-1:0]      in_row,
    input  logic [ccs_pkg::COL_W-1:0]      in_col,
    input  logic                           in_cell,
    input  logic                           cfg_valid,
    input  logic [ccs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ccs_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           cell_out,
    output logic                           status
);

    localparam int AW   = $clog2(MAX_ROWS);
    localparam int CW   = $clog2(MAX_COLS);
    localparam int RNW  = $clog2(MAX_ROWS + 1);
    localparam int CNW  = $clog2(MAX_COLS + 1);
    localparam int RNX  = RNW + 1;
    localparam int RCFG = (RNW > ccs_pkg::ROWS_CFG_W) ? RNW : ccs_pkg::ROWS_CFG_W;
    localparam int CCFG = (CNW > ccs_pkg::COLS_CFG_W) ? CNW : ccs_pkg::COLS_CFG_W;
    localparam int RCMP = (RNW > ccs_pkg::ROW_W) ? RNW : ccs_pkg::ROW_W;
    localparam int CCMP = (CNW > ccs_pkg::COL_W) ? CNW : ccs_pkg::COL_W;

    logic [ccs_pkg::THR_W-1:0]      birth_min_reg;
    logic [ccs_pkg::THR_W-1:0]      death_max_reg;
    logic [ccs_pkg::ROWS_CFG_W-1:0] rows_reg;
    logic [ccs_pkg::COLS_CFG_W-1:0] cols_reg;
    logic                           border_reg;

    logic [ccs_pkg::CMD_W-1:0] cmd_reg;
    logic [ccs_pkg::ROW_W-1:0] row_reg;
    logic [ccs_pkg::COL_W-1:0] col_reg;
    logic                      cell_in_reg;

    logic [MAX_COLS-1:0] mem [MAX_ROWS];
    logic [MAX_COLS-1:0] rd_data_reg;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [MAX_COLS-1:0] wr_data;

    logic [MAX_COLS-1:0] prev_reg, prev_next;
    logic [MAX_COLS-1:0] cur_reg, cur_next;
    logic [MAX_COLS-1:0] next_reg, next_next;
    logic [AW-1:0]       r_reg, r_next;
    logic [CW-1:0]       c_reg, c_next;

    logic out_valid_reg, out_valid_next;
    logic cell_out_reg, cell_out_next;
    logic status_reg, status_next;

    logic [RNW-1:0]      nr_eff;
    logic [CNW-1:0]      nc_eff;
    logic                addr_ok;
    logic [AW-1:0]       acc_addr;
    logic [CW-1:0]       acc_col;
    logic [MAX_COLS-1:0] border_row;
    logic                left_ok, right_ok;
    logic [CW-1:0]       left_idx, right_idx;
    logic [7:0]          nbr;
    logic [ccs_pkg::CNT_W-1:0] cnt;
    logic                alive, new_cell;
    logic                next_row_ok;
    logic                far_row_ok;
    logic [MAX_COLS-1:0] acc_row_upd;

    // effective extents
    always_comb
    begin
        if (RCFG'(rows_reg) > RCFG'(MAX_ROWS))
        begin
            nr_eff = RNW'(MAX_ROWS);
        end
        else
        begin
            nr_eff = RNW'(rows_reg);
        end
        if (CCFG'(cols_reg) > CCFG'(MAX_COLS))
        begin
            nc_eff = CNW'(MAX_COLS);
        end
        else
        begin
            nc_eff = CNW'(cols_reg);
        end
    end

    assign addr_ok    = (RCMP'(row_reg) < RCMP'(nr_eff)) && (CCMP'(col_reg) < CCMP'(nc_eff));
    assign acc_addr   = AW'(row_reg);
    assign acc_col    = CW'(col_reg);
    assign border_row = {MAX_COLS{border_reg}};

    // neighbor window around column c_reg
    assign left_ok   = (c_reg != '0);
    assign right_ok  = (CNW'(c_reg) + CNW'(1)) < nc_eff;
    assign left_idx  = left_ok ? (c_reg - CW'(1)) : c_reg;
    assign right_idx = right_ok ? (c_reg + CW'(1)) : c_reg;

    assign nbr[0] = left_ok ? prev_reg[left_idx] : border_reg;
    assign nbr[1] = prev_reg[c_reg];
    assign nbr[2] = right_ok ? prev_reg[right_idx] : border_reg;
    assign nbr[3] = left_ok ? cur_reg[left_idx] : border_reg;
    assign nbr[4] = right_ok ? cur_reg[right_idx] : border_reg;
    assign nbr[5] = left_ok ? next_reg[left_idx] : border_reg;
    assign nbr[6] = next_reg[c_reg];
    assign nbr[7] = right_ok ? next_reg[right_idx] : border_reg;

    always_comb
    begin
        cnt = '0;
        for (int i = 0; i < 8; i++)
        begin
            cnt = cnt + ccs_pkg::CNT_W'(nbr[i]);
        end
    end

    assign alive    = cur_reg[c_reg];
    assign new_cell = alive ? (cnt > death_max_reg) : (cnt >= birth_min_reg);

    assign next_row_ok = (RNX'(r_reg) + RNX'(1)) < RNX'(nr_eff);
    assign far_row_ok  = (RNX'(r_reg) + RNX'(2)) < RNX'(nr_eff);

    always_comb
    begin
        acc_row_upd          = rd_data_reg;
        acc_row_upd[acc_col] = cell_in_reg;
    end

    // operation decode
    always_comb
    begin
        rd_en          = 1'b0;
        rd_addr        = r_reg;
        wr_en          = 1'b0;
        wr_addr        = r_reg;
        wr_data        = cur_reg;
        prev_next      = prev_reg;
        cur_next       = cur_reg;
        next_next      = next_reg;
        r_next         = r_reg;
        c_next         = c_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cell_out_next  = cell_out_reg;
        status_next    = status_reg;
        case (ctl.op)
            ccs_pkg::OP_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_data = '0;
                r_next  = stat.clear_last ? '0 : r_reg + AW'(1);
            end
            ccs_pkg::OP_ACC_READ:
            begin
                rd_en   = 1'b1;
                rd_addr = acc_addr;
            end
            ccs_pkg::OP_RESPOND:
            begin
                wr_en          = addr_ok && (cmd_reg == ccs_pkg::CMD_WRITE);
                wr_addr        = acc_addr;
                wr_data        = acc_row_upd;
                out_valid_next = 1'b1;
                cell_out_next  = addr_ok && (cmd_reg == ccs_pkg::CMD_READ)
                                 && rd_data_reg[acc_col];
                status_next    = !addr_ok;
            end
            ccs_pkg::OP_G_INIT:
            begin
                prev_next = border_row;
                r_next    = '0;
                rd_en     = 1'b1;
                rd_addr   = '0;
            end
            ccs_pkg::OP_G_LOAD_CUR:
            begin
                cur_next = rd_data_reg;
                rd_en    = next_row_ok;
                rd_addr  = r_reg + AW'(1);
            end
            ccs_pkg::OP_G_LOAD_NEXT:
            begin
                next_next = next_row_ok ? rd_data_reg : border_row;
                c_next    = '0;
            end
            ccs_pkg::OP_G_CELL:
            begin
                cur_next[c_reg] = new_cell;
                c_next          = c_reg + CW'(1);
            end
            ccs_pkg::OP_G_ROW_END:
            begin
                wr_en     = 1'b1;
                wr_data   = cur_reg;
                prev_next = cur_reg;
                cur_next  = next_reg;
                r_next    = r_reg + AW'(1);
                rd_en     = far_row_ok;
                rd_addr   = r_reg + AW'(2);
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        stat.clear_last = (r_reg == AW'(MAX_ROWS - 1));
        stat.grid_empty = (nr_eff == '0) || (nc_eff == '0);
        stat.col_last   = (CNW'(c_reg) + CNW'(1)) == nc_eff;
        stat.row_last   = (RNW'(r_reg) + RNW'(1)) == nr_eff;
        stat.out_free   = !out_valid_reg || out_ready;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            birth_min_reg <= ccs_pkg::BIRTH_MIN_RST;
            death_max_reg <= ccs_pkg::DEATH_MAX_RST;
            rows_reg      <= ccs_pkg::ROWS_RST;
            cols_reg      <= ccs_pkg::COLS_RST;
            border_reg    <= 1'b0;
            r_reg         <= '0;
            c_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            r_reg         <= r_next;
            c_reg         <= c_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    ccs_pkg::CFG_BIRTH_MIN:    birth_min_reg <= cfg_data[ccs_pkg::THR_W-1:0];
                    ccs_pkg::CFG_DEATH_MAX:    death_max_reg <= cfg_data[ccs_pkg::THR_W-1:0];
                    ccs_pkg::CFG_ROWS_IN_USE:  rows_reg <= cfg_data[ccs_pkg::ROWS_CFG_W-1:0];
                    ccs_pkg::CFG_COLS_IN_USE:  cols_reg <= cfg_data[ccs_pkg::COLS_CFG_W-1:0];
                    ccs_pkg::CFG_BORDER_ALIVE: border_reg <= cfg_data[0];
                    default:                   border_reg <= border_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        prev_reg     <= prev_next;
        cur_reg      <= cur_next;
        next_reg     <= next_next;
        cell_out_reg <= cell_out_next;
        status_reg   <= status_next;
        if (ctl.latch_in)
        begin
            cmd_reg     <= in_cmd;
            row_reg     <= in_row;
            col_reg     <= in_col;
            cell_in_reg <= in_cell;
        end
    end

    // row-wide grid memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign out_valid = out_valid_reg;
    assign cell_out  = cell_out_reg;
    assign status    = status_reg;

endmodule

@@ hdl/ccs_checker.sv @@
// port-level assertions for the cellular cave smoothing block and their bind
module ccs_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic cell_out,
    input logic status
);

    // result beat held while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(cell_out) && $stable(status))
        else $error("result beat dropped or changed while stalled");

    // out-of-range address never reports a live cell
    a_status_cell: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status |-> !cell_out)
        else $error("out-of-range result with cell_out set");

    // clearing pass holds off input right after reset
    a_clear_busy: assert property (@(posedge clk)
        $rose(rst_n) |-> !in_ready)
        else $error("input taken during clearing pass");

    // a result never appears the cycle after an input beat
    a_no_instant: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared too early");

endmodule

bind cellular_cave_smoothing_top ccs_checker u_ccs_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cell_out  (out_ch.cell_out),
    .status    (out_ch.status)
);
